// ----- hdl/ipdt_pkg.sv -----
// shared types, constants and helpers of the pulse-distance ir transmitter
package ipdt_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam int ADDR_W   = 8;
	localparam int HALF_W   = 8;
	localparam int TICKS_W  = 13;
	localparam int BITS_W   = 6;
	localparam int FRAME_W  = 32;
	localparam int REG_IDX_W = 4;
	localparam int REG_DATA_W = 13;

	localparam logic [BITS_W-1:0] FRAME_BITS = BITS_W'(FRAME_W);

	localparam logic [REG_IDX_W-1:0] REG_DEFAULT_ADDRESS = 4'd0;
	localparam logic [REG_IDX_W-1:0] REG_CARRIER_HALF    = 4'd1;
	localparam logic [REG_IDX_W-1:0] REG_HEADER_MARK     = 4'd2;
	localparam logic [REG_IDX_W-1:0] REG_HEADER_SPACE    = 4'd3;
	localparam logic [REG_IDX_W-1:0] REG_BIT_MARK        = 4'd4;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_SPACE      = 4'd5;
	localparam logic [REG_IDX_W-1:0] REG_ONE_SPACE       = 4'd6;
	localparam logic [REG_IDX_W-1:0] REG_ACTIVE_LOW      = 4'd7;

	localparam logic [ADDR_W-1:0]  RST_DEFAULT_ADDRESS = 8'h07;
	localparam logic [HALF_W-1:0]  RST_CARRIER_HALF    = 8'd13;
	localparam logic [TICKS_W-1:0] RST_HEADER_MARK     = 13'd4500;
	localparam logic [TICKS_W-1:0] RST_HEADER_SPACE    = 13'd4500;
	localparam logic [TICKS_W-1:0] RST_BIT_MARK        = 13'd560;
	localparam logic [TICKS_W-1:0] RST_ZERO_SPACE      = 13'd560;
	localparam logic [TICKS_W-1:0] RST_ONE_SPACE       = 13'd1690;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR_MARK,
		PH_HDR_SPACE,
		PH_BIT_MARK,
		PH_BIT_SPACE,
		PH_STOP_MARK
	} phase_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  default_address;
		logic [HALF_W-1:0]  carrier_half_ticks;
		logic [TICKS_W-1:0] header_mark_ticks;
		logic [TICKS_W-1:0] header_space_ticks;
		logic [TICKS_W-1:0] bit_mark_ticks;
		logic [TICKS_W-1:0] zero_space_ticks;
		logic [TICKS_W-1:0] one_space_ticks;
		logic               active_low;
	} cfg_t;

	typedef struct packed {
		logic              is_start;
		logic [7:0]        command_byte;
		logic [ADDR_W-1:0] address;
	} item_t;

	typedef struct packed {
		logic ir_pin;
		logic led_on;
		logic busy_res;
		logic frame_done;
		logic rejected;
	} result_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	function automatic logic [TICKS_W-1:0] seg_len(input logic [TICKS_W-1:0] v);
		seg_len = (v == '0) ? TICKS_W'(1) : v;
	endfunction

endpackage

// ----- hdl/ipdt_fifo.sv -----
// small first-in first-out queue with show-ahead read
module ipdt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = ipdt_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd,
	output logic [WIDTH-1:0] rd_data,
	output ipdt_pkg::q_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CW'(DEPTH));
	assign do_wr = wr && !status.full;
	assign do_rd = rd && !status.empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- hdl/ipdt_front.sv -----
// front end: takes requests, resolves the address and queues them for the sequencer
module ipdt_front #(
	parameter int DEPTH = ipdt_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          cmd,
	input  logic [7:0]                    command_byte,
	input  logic [ipdt_pkg::ADDR_W-1:0]   address_override,
	input  logic [ipdt_pkg::ADDR_W-1:0]   default_address,
	input  logic                          pop,
	output ipdt_pkg::item_t               item,
	output ipdt_pkg::q_status_t           status
);

	ipdt_pkg::item_t in_item;
	ipdt_pkg::item_t rd_item;

	always_comb begin
		in_item.is_start     = cmd;
		in_item.command_byte = command_byte;
		in_item.address      = (address_override == '0) ? default_address : address_override;
	end

	ipdt_fifo #(
		.WIDTH ($bits(ipdt_pkg::item_t)),
		.DEPTH (DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push),
		.wr_data (in_item),
		.rd      (pop),
		.rd_data (rd_item),
		.status  (status)
	);

	assign item = rd_item;
	assign full = status.full;

endmodule

// ----- hdl/ipdt_back.sv -----
// back end: frame sequencer with carrier generation, one request per cycle while the result queue has room
module ipdt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ipdt_pkg::cfg_t      cfg,
	input  logic                in_valid,
	input  ipdt_pkg::item_t     item,
	output logic                take,
	input  logic                out_full,
	output ipdt_pkg::result_t   res
);

	ipdt_pkg::phase_t                    phase_q, phase_d;
	logic [ipdt_pkg::BITS_W-1:0]         bits_q, bits_d;
	logic [ipdt_pkg::FRAME_W-1:0]        shift_q, shift_d;
	logic [ipdt_pkg::TICKS_W-1:0]        ticks_q, ticks_d;
	logic [ipdt_pkg::HALF_W-1:0]         count_q, count_d;
	logic                                level_q, level_d;
	logic [ipdt_pkg::HALF_W-1:0]         half;
	logic                                is_mark;
	logic                                active;
	logic                                led;

	assign take    = in_valid && !out_full;
	assign active  = (phase_q != ipdt_pkg::PH_IDLE);
	assign is_mark = (phase_q == ipdt_pkg::PH_HDR_MARK) || (phase_q == ipdt_pkg::PH_BIT_MARK)
		|| (phase_q == ipdt_pkg::PH_STOP_MARK);
	assign half    = (cfg.carrier_half_ticks == '0) ? ipdt_pkg::HALF_W'(1) : cfg.carrier_half_ticks;

	// next state
	always_comb begin
		phase_d = phase_q;
		bits_d  = bits_q;
		shift_d = shift_q;
		ticks_d = ticks_q;
		count_d = count_q;
		level_d = level_q;
		if (take) begin
			if (item.is_start) begin
				if (!active) begin
					shift_d = {~item.command_byte, item.command_byte, item.address, item.address};
					bits_d  = '0;
					phase_d = ipdt_pkg::PH_HDR_MARK;
					ticks_d = ipdt_pkg::seg_len(cfg.header_mark_ticks);
					count_d = '0;
					level_d = 1'b1;
				end
			end else if (active) begin
				if (is_mark) begin
					count_d = count_q + ipdt_pkg::HALF_W'(1);
					if (count_d >= half) begin
						count_d = '0;
						level_d = ~level_q;
					end
				end
				if (ticks_q > ipdt_pkg::TICKS_W'(1)) begin
					ticks_d = ticks_q - ipdt_pkg::TICKS_W'(1);
				end else begin
					ticks_d = '0;
					count_d = '0;
					unique case (phase_q)
						ipdt_pkg::PH_HDR_MARK: begin
							phase_d = ipdt_pkg::PH_HDR_SPACE;
							ticks_d = ipdt_pkg::seg_len(cfg.header_space_ticks);
							level_d = 1'b0;
						end
						ipdt_pkg::PH_HDR_SPACE: begin
							phase_d = ipdt_pkg::PH_BIT_MARK;
							ticks_d = ipdt_pkg::seg_len(cfg.bit_mark_ticks);
							level_d = 1'b1;
						end
						ipdt_pkg::PH_BIT_MARK: begin
							phase_d = ipdt_pkg::PH_BIT_SPACE;
							ticks_d = ipdt_pkg::seg_len(shift_q[0] ? cfg.one_space_ticks
								: cfg.zero_space_ticks);
							level_d = 1'b0;
						end
						ipdt_pkg::PH_BIT_SPACE: begin
							shift_d = shift_q >> 1;
							bits_d  = bits_q + ipdt_pkg::BITS_W'(1);
							phase_d = (bits_d >= ipdt_pkg::FRAME_BITS) ? ipdt_pkg::PH_STOP_MARK
								: ipdt_pkg::PH_BIT_MARK;
							ticks_d = ipdt_pkg::seg_len(cfg.bit_mark_ticks);
							level_d = 1'b1;
						end
						default: begin
							phase_d = ipdt_pkg::PH_IDLE;
							level_d = 1'b0;
						end
					endcase
				end
			end
		end
	end

	// outputs
	always_comb begin
		led            = !item.is_start && active && is_mark && level_q;
		res.led_on     = led;
		res.ir_pin     = led ^ cfg.active_low;
		res.busy_res   = item.is_start || active;
		res.rejected   = item.is_start && active;
		res.frame_done = !item.is_start && (phase_q == ipdt_pkg::PH_STOP_MARK)
			&& (ticks_q <= ipdt_pkg::TICKS_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ipdt_pkg::PH_IDLE;
			bits_q  <= '0;
			shift_q <= '0;
			ticks_q <= '0;
			count_q <= '0;
			level_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			ticks_q <= ticks_d;
			count_q <= count_d;
			level_q <= level_d;
		end
	end

endmodule

// ----- hdl/ir_pulse_distance_transmitter.sv -----
// top level of the pulse-distance infrared transmitter
//
// input queue: push a request (cmd 0 = one 1 us tick, cmd 1 = start a frame with
// command_byte and address_override, 0 meaning the default address) while full is low.
// result queue: one result per request, oldest on ir_pin, led_on, busy_res,
// frame_done and rejected while empty is low; pop takes it.
// a request goes through a front queue, the frame sequencer and a result queue:
// it is registered in the front queue and then in the result queue before its
// result shows on the result ports and can be popped.
// throughput is one request per cycle; the sequencer handles one request a cycle
// and stops only when the result queue is full.
// when the receiver does not pop, the result queue fills, the sequencer holds,
// then the input queue fills and full rises; nothing is lost.
// reset clears both queues, puts the sequencer in idle with the led off and
// loads the register defaults.
// registers are written through wr_en, wr_index and wr_data; unknown indexes
// are ignored. writes are meant for times when no request is in flight.
module ir_pulse_distance_transmitter #(
	parameter int QUEUE_DEPTH = ipdt_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [ipdt_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [ipdt_pkg::REG_DATA_W-1:0]   wr_data,
	input  logic                              push,
	output logic                              full,
	input  logic                              cmd,
	input  logic [7:0]                        command_byte,
	input  logic [ipdt_pkg::ADDR_W-1:0]       address_override,
	output logic                              empty,
	input  logic                              pop,
	output logic                              ir_pin,
	output logic                              led_on,
	output logic                              busy_res,
	output logic                              frame_done,
	output logic                              rejected
);

	ipdt_pkg::cfg_t      cfg_q;
	ipdt_pkg::item_t     item;
	ipdt_pkg::q_status_t front_status;
	ipdt_pkg::q_status_t out_status;
	ipdt_pkg::result_t   res;
	ipdt_pkg::result_t   out_res;
	logic                take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_address    <= ipdt_pkg::RST_DEFAULT_ADDRESS;
			cfg_q.carrier_half_ticks <= ipdt_pkg::RST_CARRIER_HALF;
			cfg_q.header_mark_ticks  <= ipdt_pkg::RST_HEADER_MARK;
			cfg_q.header_space_ticks <= ipdt_pkg::RST_HEADER_SPACE;
			cfg_q.bit_mark_ticks     <= ipdt_pkg::RST_BIT_MARK;
			cfg_q.zero_space_ticks   <= ipdt_pkg::RST_ZERO_SPACE;
			cfg_q.one_space_ticks    <= ipdt_pkg::RST_ONE_SPACE;
			cfg_q.active_low         <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				ipdt_pkg::REG_DEFAULT_ADDRESS: cfg_q.default_address    <= wr_data[7:0];
				ipdt_pkg::REG_CARRIER_HALF:    cfg_q.carrier_half_ticks <= wr_data[7:0];
				ipdt_pkg::REG_HEADER_MARK:     cfg_q.header_mark_ticks  <= wr_data;
				ipdt_pkg::REG_HEADER_SPACE:    cfg_q.header_space_ticks <= wr_data;
				ipdt_pkg::REG_BIT_MARK:        cfg_q.bit_mark_ticks     <= wr_data;
				ipdt_pkg::REG_ZERO_SPACE:      cfg_q.zero_space_ticks   <= wr_data;
				ipdt_pkg::REG_ONE_SPACE:       cfg_q.one_space_ticks    <= wr_data;
				ipdt_pkg::REG_ACTIVE_LOW:      cfg_q.active_low         <= wr_data[0];
				default: ;
			endcase
		end
	end

	ipdt_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.cmd              (cmd),
		.command_byte     (command_byte),
		.address_override (address_override),
		.default_address  (cfg_q.default_address),
		.pop              (take),
		.item             (item),
		.status           (front_status)
	);

	ipdt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (!front_status.empty),
		.item     (item),
		.take     (take),
		.out_full (out_status.full),
		.res      (res)
	);

	ipdt_fifo #(
		.WIDTH ($bits(ipdt_pkg::result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (take),
		.wr_data (res),
		.rd      (pop),
		.rd_data (out_res),
		.status  (out_status)
	);

	assign empty      = out_status.empty;
	assign ir_pin     = out_res.ir_pin;
	assign led_on     = out_res.led_on;
	assign busy_res   = out_res.busy_res;
	assign frame_done = out_res.frame_done;
	assign rejected   = out_res.rejected;

	a_take_room: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !out_status.full && !front_status.empty)
		else $error("sequencer took a request without room or data");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(rejected && !busy_res))
		else $error("rejected result without busy");

	a_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(frame_done && (rejected || !busy_res)))
		else $error("frame done on a start or idle request");

	a_pin_polarity: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (res.ir_pin == (res.led_on ^ cfg_q.active_low)))
		else $error("pin level does not follow led and polarity");

endmodule
